/* design/dst_pkg.sv */
// Shared types and constants for the delimiter-set tokenizer.
// Used by every module and interface of the block; no dependencies.

package dst_pkg;

    // Sizes fixed by the entry format
    localparam int START_W = 16;
    localparam int LEN_W   = 17;
    localparam int INDEX_W = 16;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 16;

    // Delimiter set
    localparam int DELIM_SLOTS_C   = 8;
    localparam int MAX_DELIMITERS  = 8;
    localparam int DELIM_CNT_W     = 4;
    localparam int DELIM_BYTES_W   = DELIM_SLOTS_C * BYTE_W;

    // Default cap on the pending word length
    localparam longint unsigned MAX_STRING_LEN_C = 64'd65536;

    // Configuration port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;
    localparam logic REG_DELIM_BYTES = 1'b0;
    localparam logic REG_DELIM_COUNT = 1'b1;

    // Entry queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Scan phase, one-hot
    typedef enum logic [2:0] {
        PH_LEAD  = 3'b001,
        PH_WORD  = 3'b010,
        PH_TRAIL = 3'b100
    } phase_t;

    // One result entry
    typedef struct packed {
        logic [START_W-1:0] entry_start;
        logic [LEN_W-1:0]   entry_length;
        logic [INDEX_W-1:0] entry_index;
        logic               last_entry;
    } entry_t;

    // Entries pushed by the front in one cycle (zero, one or two)
    typedef struct packed {
        logic [1:0] count;
        entry_t     first;
        entry_t     second;
    } push_t;

endpackage

/* design/dst_char_if.sv */
// Byte channel of the delimiter-set tokenizer: valid/ready plus one string byte.
// Depends on dst_pkg.

interface dst_char_if
    import dst_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_byte;
    logic              last_char;

    modport source (output valid, output char_byte, output last_char, input ready);
    modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

/* design/dst_entry_if.sv */
// Entry channel of the delimiter-set tokenizer: valid/ready plus one entry.
// Depends on dst_pkg.

interface dst_entry_if
    import dst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [START_W-1:0] entry_start;
    logic [LEN_W-1:0]   entry_length;
    logic [INDEX_W-1:0] entry_index;
    logic               last_entry;

    modport source (output valid, output entry_start, output entry_length,
                    output entry_index, output last_entry, input ready);
    modport sink   (input valid, input entry_start, input entry_length,
                    input entry_index, input last_entry, output ready);
endinterface

/* design/delimiter_set_tokenizer.sv */
// Delimiter-set tokenizer top level: config registers, front, queue, back.
// Depends on dst_pkg, dst_char_if, dst_entry_if and all dst_* modules.
//
// Usage:
//   chars   - one string byte per transaction, last_char on the final byte.
//   entries - one entry per transaction: start offset, length (trailing
//             delimiters included, zero for a leading delimiter), running
//             index and last_entry on the final entry of the string.
//   APB     - register 0 (address 0) holds up to eight delimiter bytes,
//             register 1 (address 8) the number in use. Write while idle.
// Throughput: one byte per cycle. A byte that both closes a word and ends
//   the string yields two entries; the four-entry queue absorbs them and
//   chars.ready drops when fewer than two queue slots are free.
// Entry path: an entry is written into the queue at the edge that accepts its
//   byte, then loaded into the output register, from which it is offered.
// Reset: scan state, queue pointers and output valid clear; the delimiter count
//   resets to zero, so no byte is a delimiter until configured.
// Receiver stall: entries hold in the output register and queue; with three
//   or more queued, chars.ready goes low and the byte stream waits.

module delimiter_set_tokenizer
    import dst_pkg::*;
#(
    parameter longint unsigned MaxStringLen = MAX_STRING_LEN_C
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    dst_char_if.sink              chars,
    dst_entry_if.source           entries,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [DELIM_BYTES_W-1:0] delim_bytes;
    logic [DELIM_CNT_W-1:0]   delim_count;
    push_t                    push;
    entry_t                   head;
    logic                     not_empty;
    logic                     space_ok;
    logic                     pop;

    // configuration registers
    dst_cfg_regs u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .delim_bytes (delim_bytes),
        .delim_count (delim_count)
    );

    // classify bytes and build entries
    dst_front #(
        .MaxStringLen (MaxStringLen)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars),
        .delim_bytes (delim_bytes),
        .delim_count (delim_count),
        .space_ok    (space_ok),
        .push        (push)
    );

    // decoupling queue
    dst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .space_ok  (space_ok)
    );

    // output stage
    dst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .entries   (entries)
    );

endmodule

/* design/dst_cfg_regs.sv */
// APB-style register file: delimiter byte set and delimiter count.
// Depends on dst_pkg.

module dst_cfg_regs
    import dst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    output logic [DELIM_BYTES_W-1:0] delim_bytes,
    output logic [DELIM_CNT_W-1:0]   delim_count
);

    logic [DELIM_BYTES_W-1:0] delim_bytes_reg;
    logic [DELIM_CNT_W-1:0]   delim_count_reg;
    logic                     wr_en;
    logic                     reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_W-1];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_bytes_reg <= '0;
            delim_count_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_DELIM_BYTES: delim_bytes_reg <= pwdata[DELIM_BYTES_W-1:0];
                REG_DELIM_COUNT: delim_count_reg <= pwdata[DELIM_CNT_W-1:0];
                default:         delim_count_reg <= delim_count_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_sel)
            REG_DELIM_BYTES: prdata = APB_DATA_W'(delim_bytes_reg);
            REG_DELIM_COUNT: prdata = APB_DATA_W'(delim_count_reg);
            default:         prdata = '0;
        endcase
    end

    assign delim_bytes = delim_bytes_reg;
    assign delim_count = delim_count_reg;

endmodule

/* design/dst_front.sv */
// Front end: accepts string bytes, matches them against the delimiter set,
// tracks the scan state and pushes up to two finished entries per byte.
// Depends on dst_pkg and dst_char_if.

module dst_front
    import dst_pkg::*;
#(
    parameter longint unsigned MaxStringLen = MAX_STRING_LEN_C
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    dst_char_if.sink                 chars,
    input  logic [DELIM_BYTES_W-1:0] delim_bytes,
    input  logic [DELIM_CNT_W-1:0]   delim_count,
    input  logic                     space_ok,
    output push_t                    push
);

    // pending length register holds the cap; output takes the low bits
    localparam int CAP_W  = $clog2(MaxStringLen + 64'd1);
    localparam int WLEN_W = (CAP_W > LEN_W) ? CAP_W : LEN_W;
    localparam logic [WLEN_W-1:0] LEN_CAP = WLEN_W'(MaxStringLen);
    localparam logic [DELIM_CNT_W-1:0] DELIM_MAX = DELIM_CNT_W'(MAX_DELIMITERS);

    phase_t              phase_reg, phase_next, phase_mid;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [START_W-1:0]  start_reg, start_next, start_mid;
    logic [WLEN_W-1:0]   len_reg, len_next, len_mid, len_inc;
    logic [INDEX_W-1:0]  cnt_reg, cnt_next, cnt_mid;
    logic [DELIM_CNT_W-1:0] delim_used;
    logic                is_delim;
    logic                fire;
    logic                emit_a;
    logic                emit_last;
    entry_t              ent_a;
    entry_t              ent_last;

    assign chars.ready = space_ok;
    assign fire        = chars.valid && chars.ready;

    // parallel delimiter compare
    assign delim_used = (delim_count > DELIM_MAX) ? DELIM_MAX : delim_count;

    always_comb
    begin
        is_delim = 1'b0;
        for (int i = 0; i < MAX_DELIMITERS; i++)
        begin
            if ((DELIM_CNT_W'(i) < delim_used) &&
                (chars.char_byte == delim_bytes[BYTE_W*i +: BYTE_W]))
            begin
                is_delim = 1'b1;
            end
        end
    end

    // saturating length step
    assign len_inc = (len_reg < LEN_CAP) ? (len_reg + WLEN_W'(1)) : len_reg;

    // scan step for the current byte
    always_comb
    begin
        phase_mid = phase_reg;
        start_mid = start_reg;
        len_mid   = len_reg;
        cnt_mid   = cnt_reg;
        emit_a    = 1'b0;
        ent_a     = '{entry_start: pos_reg, entry_length: '0,
                      entry_index: cnt_reg, last_entry: chars.last_char};
        case (phase_reg)
            PH_LEAD:
            begin
                if (is_delim)
                begin
                    // leading delimiter: empty entry
                    emit_a  = 1'b1;
                    cnt_mid = cnt_reg + INDEX_W'(1);
                end
                else
                begin
                    start_mid = pos_reg;
                    len_mid   = WLEN_W'(1);
                    phase_mid = PH_WORD;
                end
            end
            PH_WORD:
            begin
                len_mid = len_inc;
                if (is_delim)
                begin
                    phase_mid = PH_TRAIL;
                end
            end
            PH_TRAIL:
            begin
                if (is_delim)
                begin
                    len_mid = len_inc;
                end
                else
                begin
                    // next word begins: close the pending one
                    emit_a    = 1'b1;
                    ent_a     = '{entry_start: start_reg, entry_length: len_reg[LEN_W-1:0],
                                  entry_index: cnt_reg, last_entry: 1'b0};
                    cnt_mid   = cnt_reg + INDEX_W'(1);
                    start_mid = pos_reg;
                    len_mid   = WLEN_W'(1);
                    phase_mid = PH_WORD;
                end
            end
            default:
            begin
                phase_mid = PH_LEAD;
            end
        endcase

        // end of string flushes the pending word
        emit_last = chars.last_char && (phase_mid != PH_LEAD);
        ent_last  = '{entry_start: start_mid, entry_length: len_mid[LEN_W-1:0],
                      entry_index: cnt_mid, last_entry: 1'b1};
    end

    // pack pushes into the queue
    always_comb
    begin
        push.count  = 2'd0;
        push.first  = ent_a;
        push.second = ent_last;
        if (emit_a)
        begin
            push.count = emit_last ? 2'd2 : 2'd1;
        end
        else
        begin
            push.first = ent_last;
            push.count = emit_last ? 2'd1 : 2'd0;
        end
        if (!fire)
        begin
            push.count = 2'd0;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        if (fire)
        begin
            if (chars.last_char)
            begin
                phase_next = PH_LEAD;
                pos_next   = '0;
                start_next = '0;
                len_next   = '0;
                cnt_next   = '0;
            end
            else
            begin
                phase_next = phase_mid;
                pos_next   = pos_reg + POS_W'(1);
                start_next = start_mid;
                len_next   = len_mid;
                cnt_next   = cnt_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* design/dst_queue.sv */
// Short entry queue between front and back: two writes, one read per cycle.
// Depends on dst_pkg.

module dst_queue
    import dst_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    input  logic   pop,
    output entry_t head,
    output logic   not_empty,
    output logic   space_ok
);

    entry_t             slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic [QPTR_W-1:0]  wr_ptr_b;

    assign wr_ptr_b  = wr_ptr_reg + QPTR_W'(1);
    assign head      = slots_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    // room for the worst case of two entries from one byte
    assign space_ok  = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = pop ? (rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slots_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            slots_reg[wr_ptr_b] <= push.second;
        end
    end

endmodule

/* design/dst_back.sv */
// Back end: output register that drains the entry queue onto the entry channel.
// Depends on dst_pkg and dst_entry_if.

module dst_back
    import dst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_t      head,
    input  logic        not_empty,
    output logic        pop,
    dst_entry_if.source entries
);

    logic   valid_reg, valid_next;
    entry_t data_reg;

    // load whenever the register is empty or being drained
    assign pop        = not_empty && (!valid_reg || entries.ready);
    assign valid_next = pop || (valid_reg && !entries.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head;
        end
    end

    assign entries.valid        = valid_reg;
    assign entries.entry_start  = data_reg.entry_start;
    assign entries.entry_length = data_reg.entry_length;
    assign entries.entry_index  = data_reg.entry_index;
    assign entries.last_entry   = data_reg.last_entry;

endmodule

/* tb/tb_delimiter_set_tokenizer.sv */
`timescale 1ns / 100ps
// Self-checking testbench for delimiter_set_tokenizer: directed byte table, then random strings.
// Depends on dst_pkg, dst_char_if, dst_entry_if and the design top level.

module tb_delimiter_set_tokenizer;
    import dst_pkg::*;

    // APB byte addresses (64-bit registers, 8*i)
    localparam logic [APB_ADDR_W-1:0] ADDR_DELIM_BYTES = 4'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_DELIM_COUNT = 4'd8;

    localparam logic [63:0] DIR_DELIMS   = 64'h2E3A3B2C0920FF00;
    localparam int          PHASES       = 6;
    localparam int          PHASE_ITEMS  = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SETTLE       = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              lst;
        logic              typed;
        entry_t            want;
    } byte_case_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dst_char_if  chars ();
    dst_entry_if entries ();

    delimiter_set_tokenizer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .entries (entries),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register shadows
    logic [63:0] delim_sh = '0;
    logic [3:0]  dcnt_sh  = '0;

    // Tokenizer state mirror
    phase_t        scan_ph  = PH_LEAD;
    logic [15:0]   scan_pos = '0;
    logic [15:0]   wstart   = '0;
    logic [16:0]   wlen     = '0;
    logic [15:0]   ent_cnt  = '0;

    entry_t     pending_entries [$];
    byte_case_t directed_bytes  [$];

    int  fail_cnt       = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_req       = 0;
    int  hold_count     = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(64'd20_000_000);
        $display("delimiter_set_tokenizer verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic bit is_delimiter(logic [7:0] b);
        int act;
        act = (dcnt_sh > MAX_DELIMITERS) ? MAX_DELIMITERS : int'(dcnt_sh);
        for (int i = 0; i < act; i++)
            if (delim_sh[8*i +: 8] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void grow_word();
        if (64'(wlen) < MAX_STRING_LEN_C)
            wlen = wlen + 17'd1;
    endfunction

    function automatic void restart_scan();
        scan_ph  = PH_LEAD;
        scan_pos = '0;
        wstart   = '0;
        wlen     = '0;
        ent_cnt  = '0;
    endfunction

    function automatic void push_entry(logic [15:0] s, logic [16:0] l, logic lst);
        entry_t e;
        e.entry_start  = s;
        e.entry_length = l;
        e.entry_index  = ent_cnt;
        e.last_entry   = lst;
        pending_entries.push_back(e);
        ent_cnt = ent_cnt + 16'd1;
    endfunction

    // Advances the mirror by one byte, queues its entries, returns how many
    function automatic int tokenize_char(logic [7:0] b, logic lst);
        int          made;
        bit          d;
        logic [15:0] p;
        made = 0;
        d    = is_delimiter(b);
        p    = scan_pos;
        case (scan_ph)
            PH_LEAD:
            begin
                if (d)
                begin
                    push_entry(p, '0, lst);
                    made++;
                end
                else
                begin
                    wstart  = p;
                    wlen    = 17'd1;
                    scan_ph = PH_WORD;
                end
            end
            PH_WORD:
            begin
                grow_word();
                if (d)
                    scan_ph = PH_TRAIL;
            end
            default:
            begin
                if (d)
                    grow_word();
                else
                begin
                    push_entry(wstart, wlen, 1'b0);
                    made++;
                    wstart  = p;
                    wlen    = 17'd1;
                    scan_ph = PH_WORD;
                end
            end
        endcase
        scan_pos = scan_pos + 16'd1;
        // end of string flushes the pending word and clears the scan
        if (lst)
        begin
            if (scan_ph != PH_LEAD)
            begin
                push_entry(wstart, wlen, 1'b1);
                made++;
            end
            restart_scan();
        end
        return made;
    endfunction

    function automatic void check_entry(entry_t want, entry_t seen);
        if (seen.entry_start !== want.entry_start)
        begin
            $error("entry_start: expected %0d, got %0d", want.entry_start, seen.entry_start);
            fail_cnt++;
        end
        if (seen.entry_length !== want.entry_length)
        begin
            $error("entry_length: expected %0d, got %0d", want.entry_length, seen.entry_length);
            fail_cnt++;
        end
        if (seen.entry_index !== want.entry_index)
        begin
            $error("entry_index: expected %0d, got %0d", want.entry_index, seen.entry_index);
            fail_cnt++;
        end
        if (seen.last_entry !== want.last_entry)
        begin
            $error("last_entry: expected %0d, got %0d", want.last_entry, seen.last_entry);
            fail_cnt++;
        end
    endfunction

    function automatic byte_case_t byte_case(logic [7:0] ch, logic lst, logic typed,
                                             int s, int l, int idx, logic le);
        byte_case_t r;
        r.ch                = ch;
        r.lst               = lst;
        r.typed             = typed;
        r.want.entry_start  = 16'(s);
        r.want.entry_length = 17'(l);
        r.want.entry_index  = 16'(idx);
        r.want.last_entry   = le;
        return r;
    endfunction

    // Delimiter from the active slots, or any byte when none is active
    function automatic logic [7:0] pick_delim();
        int act;
        int slot;
        act = (dcnt_sh > MAX_DELIMITERS) ? MAX_DELIMITERS : int'(dcnt_sh);
        if (act == 0)
            return 8'($urandom);
        slot = $urandom_range(act - 1);
        return delim_sh[8*slot +: 8];
    endfunction

    // ---------------------------------------------------------------
    // Entry checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : check_entries
        entry_t seen;
        entry_t want;
        if (rst_n && entries.valid && entries.ready)
        begin
            seen.entry_start  = entries.entry_start;
            seen.entry_length = entries.entry_length;
            seen.entry_index  = entries.entry_index;
            seen.last_entry   = entries.last_entry;
            if (pending_entries.size() == 0)
            begin
                $error("entry transaction with nothing expected: start %0d length %0d",
                       seen.entry_start, seen.entry_length);
                fail_cnt++;
            end
            else
            begin
                want = pending_entries.pop_front();
                check_entry(want, seen);
            end
        end
    end

    // ---------------------------------------------------------------
    // Entry receiver: random stalls, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        entries.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                entries.ready <= 1'b0;
                hold_count++;
                if (hold_count >= HOLD_CYCLES)
                begin
                    hold_req   = 1'b0;
                    hold_count = 0;
                end
            end
            else
                entries.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Offers one byte after a random gap; valid stays high after the transaction
    task automatic send_char(input logic [7:0] b, input logic lst, output int got);
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid     <= 1'b1;
        chars.char_byte <= b;
        chars.last_char <= lst;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        got = tokenize_char(b, lst);
    endtask

    // Stops the byte stream until every expected entry has arrived
    task automatic drain(input int settle);
        chars.valid <= 1'b0;
        @(posedge clk);
        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] a, input logic [63:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (a == ADDR_DELIM_BYTES)
            delim_sh = d;
        else if (a == ADDR_DELIM_COUNT)
            dcnt_sh = d[3:0];
        @(posedge clk);
    endtask

    task automatic set_delims(input logic [63:0] bytes, input logic [3:0] cnt);
        apb_write(ADDR_DELIM_BYTES, bytes);
        apb_write(ADDR_DELIM_COUNT, 64'(cnt));
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        int          got;
        int          phase_items;
        int          str_len;
        logic [7:0]  b;
        logic [63:0] cfg_bytes;
        logic [3:0]  cfg_cnt;
        int          ph_send [PHASES];
        int          ph_recv [PHASES];
        int          ph_cnt  [PHASES];

        chars.valid     = 1'b0;
        chars.char_byte = '0;
        chars.last_char = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        rst_n           = 1'b0;

        ph_send = '{0, 76, 0, 13, 0, 13};
        ph_recv = '{0, 0, 76, 13, 0, 13};
        ph_cnt  = '{8, 0, 1, 15, 9, 0};

        // Row 0 runs on reset registers: no delimiters at all
        directed_bytes.push_back(byte_case(8'h00, 1'b1, 1'b1, 0, 1, 0, 1'b1));
        // Two leading delimiters, word with trailing delimiters, word closed by end
        directed_bytes.push_back(byte_case(8'h00, 1'b0, 1'b1, 0, 0, 0, 1'b0));
        directed_bytes.push_back(byte_case(8'hFF, 1'b0, 1'b1, 1, 0, 1, 1'b0));
        directed_bytes.push_back(byte_case(8'h41, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_bytes.push_back(byte_case(8'h42, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_bytes.push_back(byte_case(8'h2C, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_bytes.push_back(byte_case(8'h20, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_bytes.push_back(byte_case(8'h43, 1'b0, 1'b1, 2, 4, 2, 1'b0));
        directed_bytes.push_back(byte_case(8'h2E, 1'b1, 1'b1, 6, 2, 3, 1'b1));
        // One-byte word string, one-delimiter string
        directed_bytes.push_back(byte_case(8'h7F, 1'b1, 1'b1, 0, 1, 0, 1'b1));
        directed_bytes.push_back(byte_case(8'h2E, 1'b1, 1'b1, 0, 0, 0, 1'b1));
        // Word ending on a delimiter
        directed_bytes.push_back(byte_case(8'h01, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_bytes.push_back(byte_case(8'h3A, 1'b1, 1'b1, 0, 2, 0, 1'b1));
        // Final byte both closes a word and ends the string: two entries
        directed_bytes.push_back(byte_case(8'hFE, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_bytes.push_back(byte_case(8'hFE, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_bytes.push_back(byte_case(8'h2E, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_bytes.push_back(byte_case(8'h80, 1'b1, 1'b1, 0, 3, 0, 1'b0));
        // Delimiters only
        directed_bytes.push_back(byte_case(8'h09, 1'b0, 1'b1, 0, 0, 0, 1'b0));
        directed_bytes.push_back(byte_case(8'h09, 1'b0, 1'b1, 1, 0, 1, 1'b0));
        directed_bytes.push_back(byte_case(8'h3B, 1'b1, 1'b1, 2, 0, 2, 1'b1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < directed_bytes.size(); i++)
        begin
            send_char(directed_bytes[i].ch, directed_bytes[i].lst, got);
            if (directed_bytes[i].typed)
            begin
                if (got == 0)
                begin
                    $error("entry count: expected at least 1, got 0");
                    fail_cnt++;
                end
                else
                    check_entry(directed_bytes[i].want,
                                pending_entries[pending_entries.size() - got]);
            end
            if (i == 0)
            begin
                drain(SETTLE);
                set_delims(DIR_DELIMS, 4'd8);
            end
        end
        drain(SETTLE);

        // Random phases, one register setting and idling mix each
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 2)
                cfg_bytes = '0;
            else if (p == 3)
                cfg_bytes = '1;
            else
                cfg_bytes = {$urandom, $urandom};
            cfg_cnt = (p == PHASES - 1) ? 4'($urandom_range(15)) : 4'(ph_cnt[p]);
            set_delims(cfg_bytes, cfg_cnt);
            send_idle_pct  = ph_send[p];
            recv_stall_pct = ph_recv[p];
            phase_items    = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                str_len = ($urandom_range(9) == 0) ? $urandom_range(60, 13)
                                                   : $urandom_range(12, 1);
                for (int k = 0; k < str_len; k++)
                begin
                    b = ($urandom_range(99) < 40) ? pick_delim() : 8'($urandom);
                    send_char(b, k == str_len - 1, got);
                    phase_items++;
                    // long receiver hold-off while bytes keep coming
                    if (p == 4 && phase_items == 100)
                        hold_req = 1'b1;
                    // sender waits for every entry, mid-string
                    if (p == 4 && phase_items == 220)
                        drain(0);
                end
            end
            drain(SETTLE);
        end

        if (fail_cnt == 0)
            $display("delimiter_set_tokenizer verification clean");
        else
            $display("delimiter_set_tokenizer verification failed");
        $finish;
    end

endmodule
